// File: hw/rtl/gtp_pkg.sv
// Shared types, constants and the arctangent table for the go-to-point steering core.
package gtp_pkg;

    localparam int CORDIC_STAGES_DEF = 20;
    localparam int CORDIC_STAGES_MAX = 30;
    localparam int XY_W = 35;
    localparam int Z_W = 33;

    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 33'sd843314856;
    localparam logic [31:0] GAIN_P_RESET = 32'd13107200;
    localparam logic [30:0] MAX_LINEAR_RESET = 31'd65536;
    localparam logic [33:0] DIST_LIMIT = 34'd6554;
    localparam logic signed [19:0] ANGLE_LIMIT = 20'sd6554;

    localparam logic REG_GAIN_P = 1'b0;
    localparam logic REG_MAX_LINEAR = 1'b1;

    typedef struct packed {
        logic rev;
        logic zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } gtp_vec_t;

    function automatic logic signed [Z_W-1:0] atan_q29(input int idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            0: r = 33'sd421657428;
            1: r = 33'sd248918915;
            2: r = 33'sd131521918;
            3: r = 33'sd66762579;
            4: r = 33'sd33510843;
            5: r = 33'sd16771758;
            6: r = 33'sd8387925;
            7: r = 33'sd4194219;
            8: r = 33'sd2097141;
            9: r = 33'sd1048575;
            10: r = 33'sd524288;
            11: r = 33'sd262144;
            12: r = 33'sd131072;
            13: r = 33'sd65536;
            14: r = 33'sd32768;
            15: r = 33'sd16384;
            16: r = 33'sd8192;
            17: r = 33'sd4096;
            18: r = 33'sd2048;
            19: r = 33'sd1024;
            20: r = 33'sd512;
            21: r = 33'sd256;
            22: r = 33'sd128;
            23: r = 33'sd64;
            24: r = 33'sd32;
            25: r = 33'sd16;
            26: r = 33'sd8;
            27: r = 33'sd4;
            28: r = 33'sd2;
            29: r = 33'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/go_to_point_steering_core.sv
// Top level of the go-to-point steering core.
// Input words on s_tdata carry the goal offset (x low, y high, signed Q16.16 m);
// s_tuser carries position_valid (bit 0) and reverse (bit 1). An invalid word
// reuses the last valid offset, which is zero after reset.
// Output words on m_tdata carry linear_velocity (low) and angular_velocity
// (high), both signed Q16.16; m_tuser carries arrived.
// The core accepts one word per cycle while s_tready is high. The pipeline has
// one input stage, one register per CORDIC iteration, and four stages of
// scaling, gain multiplication, limiting and output register.
// When the receiver stalls, the whole pipeline holds and s_tready falls only
// while a finished word waits in the output register.
// Reset clears all valid bits, the stored offset, and loads the default gain
// and speed cap. Configuration writes through cfg_we, cfg_index and cfg_data
// take effect at once and are meant for an idle core.
module go_to_point_steering_core
#(
    parameter int CORDIC_STAGES = gtp_pkg::CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // target_x, target_y
    input  logic [1:0]  s_tuser,   // position_valid, reverse
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // linear_velocity, angular_velocity
    output logic [0:0]  m_tuser,   // arrived
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NST = (CORDIC_STAGES > gtp_pkg::CORDIC_STAGES_MAX) ?
                         gtp_pkg::CORDIC_STAGES_MAX : CORDIC_STAGES;

    logic [31:0] gain_p_reg;
    logic [30:0] max_linear_reg;
    logic en;
    logic [NST:0] v_chain;
    gtp_pkg::gtp_vec_t vec_chain [NST+1];
    logic [31:0] lin;
    logic [31:0] ang;
    logic arr;

    assign en = m_tready || !m_tvalid;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= gtp_pkg::GAIN_P_RESET;
            max_linear_reg <= gtp_pkg::MAX_LINEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gtp_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                gtp_pkg::REG_MAX_LINEAR: max_linear_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    gtp_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .accept   (s_tvalid),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .vec_valid(v_chain[0]),
        .vec      (vec_chain[0])
    );

    for (genvar i = 0; i < NST; i++)
    begin : g_cordic
        gtp_cordic_stage #(.IDX(i)) u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v_chain[i]),
            .in_vec   (vec_chain[i]),
            .out_valid(v_chain[i+1]),
            .out_vec  (vec_chain[i+1])
        );
    end

    gtp_post u_post
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (v_chain[NST]),
        .in_vec          (vec_chain[NST]),
        .gain_p          (gain_p_reg),
        .max_linear      (max_linear_reg),
        .out_valid       (m_tvalid),
        .linear_velocity (lin),
        .angular_velocity(ang),
        .arrived         (arr)
    );

    assign m_tdata = {ang, lin};
    assign m_tuser = arr;

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (m_tready || !m_tvalid))
        else $error("ready does not follow output register state");
`endif

endmodule

// File: hw/rtl/gtp_prep.sv
// Input stage: goal hold, reverse mirror and quadrant pre-rotation.
module gtp_prep
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   accept,
    input  logic [63:0]            in_data,
    input  logic [1:0]             in_user,
    output logic                   vec_valid,
    output gtp_pkg::gtp_vec_t      vec
);

    logic [31:0] last_x_reg;
    logic [31:0] last_y_reg;
    logic [31:0] sel_x;
    logic [31:0] sel_y;
    logic signed [gtp_pkg::XY_W-1:0] ext_x;
    logic signed [gtp_pkg::XY_W-1:0] ext_y;
    logic signed [gtp_pkg::XY_W-1:0] mir_x;
    gtp_pkg::gtp_vec_t vec_next;
    gtp_pkg::gtp_vec_t vec_reg;
    logic valid_reg;

    always_comb
    begin
        sel_x = in_user[0] ? in_data[31:0] : last_x_reg;
        sel_y = in_user[0] ? in_data[63:32] : last_y_reg;
        ext_x = gtp_pkg::XY_W'(signed'(sel_x));
        ext_y = gtp_pkg::XY_W'(signed'(sel_y));
        mir_x = in_user[1] ? -ext_x : ext_x;
        vec_next.rev = in_user[1];
        vec_next.zero = (sel_x == 32'd0) && (sel_y == 32'd0);
        if (mir_x < 0)
        begin
            if (ext_y >= 0)
            begin
                vec_next.x = ext_y;
                vec_next.y = -mir_x;
                vec_next.z = gtp_pkg::HALF_PI_Q29;
            end
            else
            begin
                vec_next.x = -ext_y;
                vec_next.y = mir_x;
                vec_next.z = -gtp_pkg::HALF_PI_Q29;
            end
        end
        else
        begin
            vec_next.x = mir_x;
            vec_next.y = ext_y;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= accept;
            if (accept && in_user[0])
            begin
                last_x_reg <= in_data[31:0];
                last_y_reg <= in_data[63:32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec = vec_reg;
    assign vec_valid = valid_reg;

`ifndef SYNTHESIS
    a_hold_x: assert property (@(posedge clk) disable iff (!rst_n)
        en && accept && in_user[0] |=> last_x_reg == $past(in_data[31:0]))
        else $error("stored goal x not updated");
    a_hold_y: assert property (@(posedge clk) disable iff (!rst_n)
        en && accept && in_user[0] |=> last_y_reg == $past(in_data[63:32]))
        else $error("stored goal y not updated");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg) && $stable(last_x_reg))
        else $error("input stage moved during stall");
`endif

endmodule

// File: hw/rtl/gtp_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
module gtp_cordic_stage
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  gtp_pkg::gtp_vec_t in_vec,
    output logic              out_valid,
    output gtp_pkg::gtp_vec_t out_vec
);

    gtp_pkg::gtp_vec_t vec_next;
    gtp_pkg::gtp_vec_t vec_reg;
    logic valid_reg;
    logic signed [gtp_pkg::XY_W-1:0] dx;
    logic signed [gtp_pkg::XY_W-1:0] dy;

    always_comb
    begin
        dx = in_vec.y >>> IDX;
        dy = in_vec.x >>> IDX;
        vec_next = in_vec;
        if (in_vec.y > 0)
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + gtp_pkg::atan_q29(IDX);
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - gtp_pkg::atan_q29(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_vec = vec_reg;
    assign out_valid = valid_reg;

endmodule

// File: hw/rtl/gtp_post.sv
// Scaling, gain, limiting and output register after the CORDIC pipeline.
module gtp_post
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  gtp_pkg::gtp_vec_t in_vec,
    input  logic [31:0]       gain_p,
    input  logic [30:0]       max_linear,
    output logic              out_valid,
    output logic [31:0]       linear_velocity,
    output logic [31:0]       angular_velocity,
    output logic              arrived
);

    localparam int Z_W_L = gtp_pkg::Z_W;

    logic [3:0] valid_reg;

    logic [63:0] mprod_reg;
    logic signed [19:0] ang_reg;
    logic rev1_reg;
    logic zero1_reg;
    logic signed [Z_W_L-1:0] zr;

    logic [33:0] dist_reg;
    logic signed [52:0] tprod_reg;
    logic big2_reg;
    logic rev2_reg;
    logic [63:0] mround;

    logic [65:0] sprod_reg;
    logic [31:0] turn_reg;
    logic arr3_reg;
    logic big3_reg;
    logic rev3_reg;
    logic signed [36:0] tshift;

    logic [31:0] lin_reg;
    logic [31:0] ang_out_reg;
    logic arr_reg;
    logic [49:0] spd;
    logic [30:0] spd_cap;
    logic [31:0] lin_next;

    always_comb
    begin
        zr = (in_vec.z + Z_W_L'(4096)) >>> 13;
        mround = mprod_reg + 64'h2000_0000;
        tshift = 37'(tprod_reg >>> 16);
        spd = sprod_reg[65:16];
        spd_cap = (spd > 50'(max_linear)) ? max_linear : spd[30:0];
        lin_next = rev3_reg ? -{1'b0, spd_cap} : {1'b0, spd_cap};
        if (big3_reg)
        begin
            lin_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mprod_reg <= 64'(in_vec.x[33:0]) * 64'(gtp_pkg::KINV_Q30);
            if (in_vec.zero)
            begin
                ang_reg <= '0;
            end
            else if (in_vec.rev)
            begin
                ang_reg <= -zr[19:0];
            end
            else
            begin
                ang_reg <= zr[19:0];
            end
            rev1_reg <= in_vec.rev;
            zero1_reg <= in_vec.zero;

            dist_reg <= zero1_reg ? 34'd0 : mround[63:30];
            tprod_reg <= signed'({21'd0, gain_p}) * 53'(ang_reg);
            big2_reg <= (ang_reg > gtp_pkg::ANGLE_LIMIT) || (ang_reg < -gtp_pkg::ANGLE_LIMIT);
            rev2_reg <= rev1_reg;

            sprod_reg <= 66'(gain_p) * 66'(dist_reg);
            if (tshift > 37'sd2147483647)
            begin
                turn_reg <= 32'h7FFF_FFFF;
            end
            else if (tshift < -37'sd2147483648)
            begin
                turn_reg <= 32'h8000_0000;
            end
            else
            begin
                turn_reg <= tshift[31:0];
            end
            arr3_reg <= dist_reg < gtp_pkg::DIST_LIMIT;
            big3_reg <= big2_reg;
            rev3_reg <= rev2_reg;

            lin_reg <= lin_next;
            ang_out_reg <= turn_reg;
            arr_reg <= arr3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign linear_velocity = lin_reg;
    assign angular_velocity = ang_out_reg;
    assign arrived = arr_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the go-to-point steering core.
`timescale 1ns / 1ps

module testbench;

    localparam int STAGES = gtp_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY = STAGES + 5;

    typedef struct packed {
        logic signed [31:0] angular;
        logic signed [31:0] linear;
        logic               arrived;
    } steer_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;   // linear_velocity, angular_velocity
    logic [0:0]  m_tuser;   // arrived
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] gain;
    logic [30:0] speed_cap;
    logic [31:0] goal_x;
    logic [31:0] goal_y;
    steer_cmd_t  pending_cmds[$];
    int          errors = 0;
    int          checked = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    go_to_point_steering_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic steer_cmd_t predict_steering(logic [31:0] tx, logic [31:0] ty,
                                                    logic valid, logic rev);
        steer_cmd_t c;
        longint x, y, z, t, dx, dy, ang, lin, turn;
        logic [63:0] mag, spd;
        if (valid)
        begin
            goal_x = tx;
            goal_y = ty;
        end
        x = longint'($signed(goal_x));
        y = longint'($signed(goal_y));
        if (rev)
            x = -x;
        z = 0;
        if (x == 0 && y == 0)
        begin
            ang = 0;
            mag = 0;
        end
        else
        begin
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = gtp_pkg::HALF_PI_Q29;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -gtp_pkg::HALF_PI_Q29;
                end
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (y > 0)
                begin
                    x += dx;
                    y -= dy;
                    z += gtp_pkg::atan_q29(i);
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= gtp_pkg::atan_q29(i);
                end
            end
            mag = (64'(x) * 64'(gtp_pkg::KINV_Q30) + 64'h2000_0000) >> 30;
            ang = floor_shift(z + 4096, 13);
        end
        if (rev)
            ang = -ang;
        spd = (64'(gain) * mag) >> 16;
        if (spd > 64'(speed_cap))
            spd = 64'(speed_cap);
        lin = longint'(spd);
        if (rev)
            lin = -lin;
        if (ang > 6554 || ang < -6554)
            lin = 0;
        turn = floor_shift(longint'(gain) * ang, 16);
        if (turn > 64'sd2147483647)
            turn = 64'sd2147483647;
        if (turn < -64'sd2147483648)
            turn = -64'sd2147483648;
        c.linear = lin[31:0];
        c.angular = turn[31:0];
        c.arrived = (mag < 64'd6554);
        return c;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gtp_pkg::REG_GAIN_P)
            gain = value;
        else
            speed_cap = value[30:0];
        @(posedge clk);
    endtask

    task automatic send_goal(logic [31:0] tx, logic [31:0] ty, logic valid, logic rev);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ty, tx};
        s_tuser <= {rev, valid};
        pending_cmds.push_back(predict_steering(tx, ty, valid, rev));
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        steer_cmd_t exp_cmd;
        steer_cmd_t got;
        if (m_tvalid && m_tready)
        begin
            got.linear = m_tdata[31:0];
            got.angular = m_tdata[63:32];
            got.arrived = m_tuser[0];
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                checked++;
                if (got.linear !== exp_cmd.linear)
                begin
                    errors++;
                    $display("%0t: linear expected %h actual %h", $time,
                             exp_cmd.linear, got.linear);
                end
                if (got.angular !== exp_cmd.angular)
                begin
                    errors++;
                    $display("%0t: angular expected %h actual %h", $time,
                             exp_cmd.angular, got.angular);
                end
                if (got.arrived !== exp_cmd.arrived)
                begin
                    errors++;
                    $display("%0t: arrived expected %b actual %b", $time,
                             exp_cmd.arrived, got.arrived);
                end
            end
        end
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    function automatic logic [31:0] random_coord();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return 32'($signed($urandom_range(13107, 0)) - 6554);
            2: return 32'($signed($urandom_range(1310720, 0)) - 655360);
            default: return 32'($signed($urandom_range(65536, 0)) - 32768) <<< $urandom_range(15, 0);
        endcase
    endfunction

    task automatic test_directed;
        send_goal(32'h0, 32'h0, 1'b0, 1'b0);
        send_goal(32'h0, 32'h0, 1'b1, 1'b0);
        send_goal(32'h0, 32'h0, 1'b1, 1'b1);
        send_goal(32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0);
        send_goal(32'h8000_0000, 32'h0, 1'b1, 1'b0);
        send_goal(32'h8000_0000, 32'h0, 1'b1, 1'b1);
        send_goal(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_goal(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_goal(32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_goal(32'h0, 32'h8000_0000, 1'b1, 1'b0);
        send_goal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_goal(32'h0000_1999, 32'h0, 1'b1, 1'b0);
        send_goal(32'h0000_199A, 32'h0, 1'b1, 1'b0);
        send_goal(32'h0001_0000, 32'h0000_1000, 1'b1, 1'b0);
        send_goal(32'h0001_0000, 32'h0000_2000, 1'b1, 1'b1);
        send_goal(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b1);
        send_goal(32'hFFFE_0000, 32'h0000_0100, 1'b1, 1'b0);
        send_goal(32'hFFFE_0000, 32'hFFFF_FF00, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_goal(random_coord(), random_coord(), $urandom_range(7, 0) != 0,
                      1'($urandom_range(1, 0)));
        drain();
    endtask

    task automatic test_config_sweep;
        write_reg(gtp_pkg::REG_GAIN_P, 32'hFFFF_FFFF);
        write_reg(gtp_pkg::REG_MAX_LINEAR, 32'h7FFF_FFFF);
        test_random(60);
        write_reg(gtp_pkg::REG_GAIN_P, 32'h0);
        write_reg(gtp_pkg::REG_MAX_LINEAR, 32'h0);
        test_random(40);
        write_reg(gtp_pkg::REG_GAIN_P, $urandom());
        write_reg(gtp_pkg::REG_MAX_LINEAR, $urandom());
        test_random(60);
        write_reg(gtp_pkg::REG_GAIN_P, 32'h0001_0000);
        write_reg(gtp_pkg::REG_MAX_LINEAR, 32'h0004_0000);
        test_random(60);
        write_reg(gtp_pkg::REG_GAIN_P, gtp_pkg::GAIN_P_RESET);
        write_reg(gtp_pkg::REG_MAX_LINEAR, 32'(gtp_pkg::MAX_LINEAR_RESET));
    endtask

    task automatic test_flow_control;
        send_idle_pct = 76;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        test_random(150);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        gain = gtp_pkg::GAIN_P_RESET;
        speed_cap = gtp_pkg::MAX_LINEAR_RESET;
        goal_x = '0;
        goal_y = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        test_config_sweep();
        test_flow_control();
        $display("Covered directed extremes, four gain and cap settings and stalls on both sides;");
        $display("%0d words checked.", checked);
        if (errors == 0 && pending_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
